/* hw/rtl/nfca_pkg.sv */
// ----------------------------------------------------------------------------
// nfca_pkg
// shared widths and constants of the next-fit coalescing allocator
// ----------------------------------------------------------------------------
package nfca_pkg;

  localparam int BYTES_W     = 16;
  localparam int NEED_W      = 15;
  localparam int PORT_ADDR_W = 13;
  localparam int GROW_W      = 13;
  localparam int RECIP_SHIFT = 24;

  localparam logic [GROW_W-1:0] GROW_RESET = 13'd1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

/* hw/rtl/next_fit_coalescing_allocator.sv */
// ----------------------------------------------------------------------------
// next_fit_coalescing_allocator
// next-fit free list allocator with address-ordered coalescing free
// free walks the list nodes from the rover, then coalesces with adjacent ones;
// allocate walks from the rover, with a split step when the block is larger,
// and an arena growth frees the new block and restarts the walk; one read per
// cycle of the header memories sets the walk rate; result strobes once, no stall
// reset: the S_INIT state writes the sentinel header, busy stays high meanwhile
// ----------------------------------------------------------------------------
module next_fit_coalescing_allocator #(
  parameter int ARENA_UNITS = 4096,
  parameter int UNIT_BYTES  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_cmd,
  input  logic [nfca_pkg::BYTES_W-1:0]     in_req_bytes,
  input  logic [nfca_pkg::PORT_ADDR_W-1:0] in_free_addr,
  output logic                             out_valid,
  output logic                             out_ok,
  output logic [nfca_pkg::PORT_ADDR_W-1:0] out_user_addr,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nfca_pkg::GROW_W-1:0]      cfg_data
);

  localparam int AW  = $clog2(ARENA_UNITS);
  localparam int SW  = AW + 1;
  localparam int EW  = AW + 2;
  localparam int TW  = AW + 2;
  localparam int CW  = (SW > nfca_pkg::NEED_W) ? SW + 1 : nfca_pkg::NEED_W + 1;
  localparam int GW  = (AW + 1 > nfca_pkg::NEED_W) ? AW + 2 : nfca_pkg::NEED_W + 1;
  localparam logic [SW-1:0] SZ_MASK  = SW'(2 * ARENA_UNITS - 1);
  localparam logic [TW-1:0] ALOC_LIM = TW'(2 * ARENA_UNITS + 4);
  localparam logic [TW-1:0] PUT_LIM  = TW'(ARENA_UNITS);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_A_MUL   = 4'd2;
  localparam logic [3:0] S_A_NEED  = 4'd3;
  localparam logic [3:0] S_A_LINK  = 4'd4;
  localparam logic [3:0] S_A_CHK   = 4'd5;
  localparam logic [3:0] S_A_SPLIT = 4'd6;
  localparam logic [3:0] S_A_RELD  = 4'd7;
  localparam logic [3:0] S_P_START = 4'd8;
  localparam logic [3:0] S_P_WALK  = 4'd9;
  localparam logic [3:0] S_P_BP    = 4'd10;
  localparam logic [3:0] S_P_NX    = 4'd11;
  localparam logic [3:0] S_P_CUR   = 4'd12;

  logic [AW-1:0] link_mem [0:ARENA_UNITS-1];
  logic [SW-1:0] size_mem [0:ARENA_UNITS-1];

  logic [3:0]                      state_r, state_nxt;
  logic [AW-1:0]                   rover_r, rover_nxt;
  logic [AW:0]                     brk_r, brk_nxt;
  logic [nfca_pkg::GROW_W-1:0]     grow_r;
  logic [nfca_pkg::BYTES_W-1:0]    req_r, req_nxt;
  logic [nfca_pkg::NEED_W-1:0]     need_r, need_nxt;
  logic [AW-1:0]                   cur_r, cur_nxt;
  logic [AW-1:0]                   prev_r, prev_nxt;
  logic [AW-1:0]                   bp_r, bp_nxt;
  logic [AW-1:0]                   nx_r, nx_nxt;
  logic [SW-1:0]                   szcur_r, szcur_nxt;
  logic [SW-1:0]                   szbp_r, szbp_nxt;
  logic [SW-1:0]                   nsz_r, nsz_nxt;
  logic [AW-1:0]                   nlk_r, nlk_nxt;
  logic [EW-1:0]                   spl_r, spl_nxt;
  logic [TW-1:0]                   steps_r, steps_nxt;
  logic [TW-1:0]                   pst_r, pst_nxt;
  logic                            from_alloc_r, from_alloc_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [nfca_pkg::PORT_ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic [AW-1:0] lk_q_r;
  logic [SW-1:0] sz_q_r;
  logic [AW-1:0] rd_addr;
  logic          lk_we, sz_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] lk_wd;
  logic [SW-1:0] sz_wd;

  logic [nfca_pkg::NEED_W-1:0] need_w;
  logic [nfca_pkg::NEED_W-1:0] nu;
  logic [GW-1:0]               grow_end;
  logic [SW-1:0]               s_rem;
  logic                        fa_ok;
  logic                        put_here;

  nfca_need #(.UNIT_BYTES(UNIT_BYTES)) u_need (
    .clk   (clk),
    .bytes (req_r),
    .need  (need_w)
  );

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[wr_addr] <= lk_wd;
    end
    if (sz_we) begin
      size_mem[wr_addr] <= sz_wd & SZ_MASK;
    end
    lk_q_r <= link_mem[rd_addr];
    sz_q_r <= size_mem[rd_addr];
  end

  assign nu = (need_r > nfca_pkg::NEED_W'(grow_r)) ? need_r : nfca_pkg::NEED_W'(grow_r);
  assign grow_end = GW'(brk_r) + GW'(nu);
  assign s_rem = SW'(CW'(sz_q_r) - CW'(need_r));
  assign fa_ok = (in_free_addr >= nfca_pkg::PORT_ADDR_W'(2))
              && (32'(in_free_addr) - 32'd1 < 32'(brk_r))
              && (32'(in_free_addr) - 32'd1 < 32'(ARENA_UNITS));
  assign put_here = ((bp_r > cur_r) && (bp_r < lk_q_r))
                 || ((cur_r >= lk_q_r) && ((bp_r > cur_r) || (bp_r < lk_q_r)));

  always_comb begin
    state_nxt      = state_r;
    rover_nxt      = rover_r;
    brk_nxt        = brk_r;
    req_nxt        = req_r;
    need_nxt       = need_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    bp_nxt         = bp_r;
    nx_nxt         = nx_r;
    szcur_nxt      = szcur_r;
    szbp_nxt       = szbp_r;
    nsz_nxt        = nsz_r;
    nlk_nxt        = nlk_r;
    spl_nxt        = spl_r;
    steps_nxt      = steps_r;
    pst_nxt        = pst_r;
    from_alloc_nxt = from_alloc_r;
    out_valid_nxt  = 1'b0;
    out_ok_nxt     = out_ok_r;
    out_addr_nxt   = out_addr_r;
    rd_addr        = rover_r;
    lk_we          = 1'b0;
    sz_we          = 1'b0;
    wr_addr        = cur_r;
    lk_wd          = '0;
    sz_wd          = '0;

    unique case (state_r)
      S_INIT: begin
        lk_we     = 1'b1;
        sz_we     = 1'b1;
        wr_addr   = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req_bytes;
          if (in_cmd == nfca_pkg::CMD_ALLOC) begin
            state_nxt = S_A_MUL;
          end else if (fa_ok) begin
            bp_nxt         = AW'(32'(in_free_addr) - 32'd1);
            from_alloc_nxt = 1'b0;
            state_nxt      = S_P_START;
          end else begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_addr_nxt  = '0;
          end
        end
      end
      S_A_MUL: begin
        state_nxt = S_A_NEED;
      end
      S_A_NEED: begin
        need_nxt  = need_w;
        prev_nxt  = rover_r;
        rd_addr   = rover_r;
        steps_nxt = '0;
        state_nxt = S_A_LINK;
      end
      S_A_LINK: begin
        cur_nxt   = lk_q_r;
        rd_addr   = lk_q_r;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (CW'(sz_q_r) >= CW'(need_r)) begin
          rover_nxt = prev_r;
          if (CW'(sz_q_r) == CW'(need_r)) begin
            lk_we         = 1'b1;
            wr_addr       = prev_r;
            lk_wd         = lk_q_r;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b1;
            out_addr_nxt  = nfca_pkg::PORT_ADDR_W'(32'(cur_r) + 32'd1);
            state_nxt     = S_IDLE;
          end else begin
            sz_we     = 1'b1;
            wr_addr   = cur_r;
            sz_wd     = s_rem;
            spl_nxt   = EW'(cur_r) + EW'(s_rem);
            state_nxt = S_A_SPLIT;
          end
        end else if (cur_r == rover_r) begin
          if (grow_end > GW'(ARENA_UNITS)) begin
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_addr_nxt  = '0;
            state_nxt     = S_IDLE;
          end else begin
            brk_nxt        = (AW + 1)'(grow_end);
            sz_we          = 1'b1;
            wr_addr        = AW'(brk_r);
            sz_wd          = SW'(nu);
            bp_nxt         = AW'(brk_r);
            from_alloc_nxt = 1'b1;
            state_nxt      = S_P_START;
          end
        end else if (steps_r + TW'(1) > ALOC_LIM) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_addr_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          steps_nxt = steps_r + TW'(1);
          prev_nxt  = cur_r;
          cur_nxt   = lk_q_r;
          rd_addr   = lk_q_r;
        end
      end
      S_A_SPLIT: begin
        if (32'(spl_r) < 32'(ARENA_UNITS)) begin
          sz_we   = 1'b1;
          wr_addr = AW'(spl_r);
          sz_wd   = SW'(need_r);
        end
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_addr_nxt  = nfca_pkg::PORT_ADDR_W'(32'(spl_r) + 32'd1);
        state_nxt     = S_IDLE;
      end
      S_A_RELD: begin
        if (steps_r + TW'(1) > ALOC_LIM) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_addr_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          steps_nxt = steps_r + TW'(1);
          prev_nxt  = rover_r;
          rd_addr   = rover_r;
          state_nxt = S_A_LINK;
        end
      end
      S_P_START: begin
        cur_nxt   = rover_r;
        rd_addr   = rover_r;
        pst_nxt   = '0;
        state_nxt = S_P_WALK;
      end
      S_P_WALK: begin
        if (put_here) begin
          szcur_nxt = sz_q_r;
          nx_nxt    = lk_q_r;
          rd_addr   = bp_r;
          state_nxt = S_P_BP;
        end else if (pst_r + TW'(1) > PUT_LIM) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_addr_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          pst_nxt = pst_r + TW'(1);
          cur_nxt = lk_q_r;
          rd_addr = lk_q_r;
        end
      end
      S_P_BP: begin
        szbp_nxt  = sz_q_r;
        rd_addr   = nx_r;
        state_nxt = S_P_NX;
      end
      S_P_NX: begin
        lk_we   = 1'b1;
        sz_we   = 1'b1;
        wr_addr = bp_r;
        if (EW'(bp_r) + EW'(szbp_r) == EW'(nx_r)) begin
          nsz_nxt = SW'(EW'(szbp_r) + EW'(sz_q_r));
          nlk_nxt = lk_q_r;
        end else begin
          nsz_nxt = szbp_r;
          nlk_nxt = nx_r;
        end
        lk_wd     = nlk_nxt;
        sz_wd     = nsz_nxt;
        state_nxt = S_P_CUR;
      end
      S_P_CUR: begin
        lk_we   = 1'b1;
        sz_we   = 1'b1;
        wr_addr = cur_r;
        if (EW'(cur_r) + EW'(szcur_r) == EW'(bp_r)) begin
          sz_wd = SW'(EW'(szcur_r) + EW'(nsz_r));
          lk_wd = nlk_r;
        end else begin
          sz_wd = szcur_r;
          lk_wd = bp_r;
        end
        rover_nxt = cur_r;
        if (from_alloc_r) begin
          state_nxt = S_A_RELD;
        end else begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_addr_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      rover_r     <= '0;
      brk_r       <= (AW + 1)'(1);
      grow_r      <= nfca_pkg::GROW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        grow_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    need_r       <= need_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    bp_r         <= bp_nxt;
    nx_r         <= nx_nxt;
    szcur_r      <= szcur_nxt;
    szbp_r       <= szbp_nxt;
    nsz_r        <= nsz_nxt;
    nlk_r        <= nlk_nxt;
    spl_r        <= spl_nxt;
    steps_r      <= steps_nxt;
    pst_r        <= pst_nxt;
    from_alloc_r <= from_alloc_nxt;
    out_ok_r     <= out_ok_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_user_addr = out_addr_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a transaction is still running");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_user_addr == '0))
    else $error("failed transaction returned a nonzero address");

  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(brk_r) <= 32'(ARENA_UNITS))
    else $error("arena break beyond arena");

  a_brk_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (brk_r >= $past(brk_r)))
    else $error("arena break moved backward");

endmodule

/* hw/rtl/nfca_need.sv */
// ----------------------------------------------------------------------------
// nfca_need
// byte count to units plus header, by reciprocal multiply with one correction
// ----------------------------------------------------------------------------
module nfca_need #(
  parameter int UNIT_BYTES = 16
) (
  input  logic                         clk,
  input  logic [nfca_pkg::BYTES_W-1:0] bytes,
  output logic [nfca_pkg::NEED_W-1:0]  need
);

  localparam int XW = nfca_pkg::BYTES_W + 1;
  localparam int MW = nfca_pkg::RECIP_SHIFT;
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] RECIP = MW'((1 << nfca_pkg::RECIP_SHIFT) / UNIT_BYTES);

  logic [XW-1:0] x;
  logic [XW-1:0] x_r;
  logic [PW-1:0] prod_r;
  logic [XW-1:0] q0;
  logic          corr;

  assign x = XW'(bytes) + XW'(UNIT_BYTES - 1);

  always_ff @(posedge clk) begin
    x_r    <= x;
    prod_r <= PW'(x) * PW'(RECIP);
  end

  assign q0   = prod_r[PW-1:nfca_pkg::RECIP_SHIFT];
  assign corr = ((32'(q0) + 32'd1) * 32'(UNIT_BYTES)) <= 32'(x_r);
  assign need = nfca_pkg::NEED_W'(32'(q0) + 32'(corr) + 32'd1);

endmodule
